// ===== rtl/acet_pkg.sv =====
// shared types and constants for the aabb contact event tracker
`default_nettype none

package acet_pkg;

  localparam int unsigned NumCollidersDef = 64;
  localparam int unsigned IdW             = 6;
  localparam int unsigned CoordW          = 16;
  // doubled centre plus or minus a full size, signed
  localparam int unsigned EdgeW           = CoordW + 2;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvEnter = 2'd1,
    EvStay  = 2'd2,
    EvExit  = 2'd3
  } contact_event_e;

  typedef struct packed {
    logic [IdW-1:0]           left_id;
    logic [IdW-1:0]           right_id;
    logic                     left_valid;
    logic                     right_valid;
    logic signed [CoordW-1:0] left_x;
    logic signed [CoordW-1:0] left_y;
    logic [CoordW-1:0]        left_w;
    logic [CoordW-1:0]        left_h;
    logic signed [CoordW-1:0] right_x;
    logic signed [CoordW-1:0] right_y;
    logic [CoordW-1:0]        right_w;
    logic [CoordW-1:0]        right_h;
  } in_t;

  typedef struct packed {
    contact_event_e contact_event;
    logic           overlapping;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/acet_axis_overlap.sv =====
// one-axis interval overlap test on doubled centres, touching counts
`default_nettype none

module acet_axis_overlap
  import acet_pkg::*;
(
  input  wire logic signed [CoordW-1:0] c_l_i,
  input  wire logic [CoordW-1:0]        s_l_i,
  input  wire logic signed [CoordW-1:0] c_r_i,
  input  wire logic [CoordW-1:0]        s_r_i,
  output logic                          hit_o
);

  logic signed [EdgeW-1:0] c2_l, c2_r, s_l, s_r;
  logic signed [EdgeW-1:0] l_lo, l_hi, r_lo, r_hi;

  always_comb begin
    c2_l = EdgeW'(c_l_i) <<< 1;
    c2_r = EdgeW'(c_r_i) <<< 1;
    s_l  = $signed({2'b00, s_l_i});
    s_r  = $signed({2'b00, s_r_i});
    l_lo = c2_l - s_l;
    l_hi = c2_l + s_l;
    r_lo = c2_r - s_r;
    r_hi = c2_r + s_r;
    hit_o = !((l_hi < r_lo) || (l_lo > r_hi));
  end

endmodule

`default_nettype wire

// ===== rtl/aabb_contact_event_tracker.sv =====
// top level: pair contact tracker with a touching-bit memory per ordered pair
//
// usage
//   input: raise start with an item on item_i; the transfer happens at a
//   rising edge where start is high and busy is low. one pair per item.
//   output: every accepted item gives exactly one result on result_o,
//   marked by result_valid_o for one cycle; the receiver cannot stall it.
// pipeline and throughput
//   a transfer passes through stage 1 and then the result registers. one item
//   per cycle sustained once the clearing pass is over: the touching bit is
//   read at transfer and written back from stage 1 at the next edge, and a
//   back-to-back item on the same pair takes the pending bit by forwarding.
// reset
//   after reset the memory of NUM_COLLIDERS^2 (rounded to a power of four)
//   touching bits is cleared, one entry per cycle; busy stays high until
//   every entry is cleared, 4096 entries at the default size.
// skipped pairs (an ineligible side, equal ids, an id not below
// NUM_COLLIDERS) report none, not overlapping, and leave the memory alone.
`default_nettype none

module aabb_contact_event_tracker
  import acet_pkg::*;
#(
  parameter int unsigned NUM_COLLIDERS = NumCollidersDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  item_i,
  output logic      result_valid_o,
  output out_t      result_o
);

  localparam int unsigned IdxW  = $clog2(NUM_COLLIDERS);
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned Depth = 1 << AddrW;

  // touching-bit store, one bit per ordered pair
  logic mem [Depth];

  logic             accept;
  logic             chk;
  logic             hit_x, hit_y;
  logic [AddrW-1:0] addr;

  // clearing pass after reset
  logic             clr_active_q, clr_active_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;

  // stage 1: item whose bit is being read, written back at the next edge
  logic             s1_valid_q;
  logic             s1_chk_q;
  logic             s1_hit_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_fwd_q, s1_fwd_d;
  logic             s1_fwd_bit_q;
  logic             rd_bit_q;

  logic             res_valid_q;
  out_t             res_q, res_d;

  logic             prev;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic             mem_wdata;

  assign busy   = clr_active_q;
  assign accept = start && !busy;

  // eligibility and id range
  assign chk = item_i.left_valid && item_i.right_valid
            && (item_i.left_id != item_i.right_id)
            && (32'(item_i.left_id) < NUM_COLLIDERS)
            && (32'(item_i.right_id) < NUM_COLLIDERS);

  assign addr = {IdxW'(item_i.left_id), IdxW'(item_i.right_id)};

  acet_axis_overlap u_ovl_x (
    .c_l_i (item_i.left_x),
    .s_l_i (item_i.left_w),
    .c_r_i (item_i.right_x),
    .s_r_i (item_i.right_w),
    .hit_o (hit_x)
  );

  acet_axis_overlap u_ovl_y (
    .c_l_i (item_i.left_y),
    .s_l_i (item_i.left_h),
    .c_r_i (item_i.right_y),
    .s_r_i (item_i.right_h),
    .hit_o (hit_y)
  );

  // the read at transfer misses a write-back landing on the same edge
  assign s1_fwd_d = s1_valid_q && s1_chk_q && (s1_addr_q == addr);

  // clear sweep
  always_comb begin
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == {AddrW{1'b1}}) begin
        clr_active_d = 1'b0;
      end
    end
  end

  // single write port: sweep or write-back, never both
  always_comb begin
    mem_we    = clr_active_q || (s1_valid_q && s1_chk_q);
    mem_waddr = clr_active_q ? clr_cnt_q : s1_addr_q;
    mem_wdata = clr_active_q ? 1'b0 : s1_hit_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_bit_q <= mem[addr];
    end
  end

  // event from previous bit and new overlap
  always_comb begin
    prev                  = s1_fwd_q ? s1_fwd_bit_q : rd_bit_q;
    res_d.contact_event   = EvNone;
    res_d.overlapping     = s1_chk_q && s1_hit_q;
    if (s1_chk_q) begin
      if (s1_hit_q) begin
        res_d.contact_event = prev ? EvStay : EvEnter;
      end else begin
        res_d.contact_event = prev ? EvExit : EvNone;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      s1_valid_q   <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      s1_valid_q   <= accept;
      res_valid_q  <= s1_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_chk_q     <= chk;
      s1_hit_q     <= hit_x && hit_y;
      s1_addr_q    <= addr;
      s1_fwd_q     <= s1_fwd_d;
      s1_fwd_bit_q <= s1_hit_q;
    end
    if (s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 result_valid_o)
    else $error("transfer without result two cycles later");

  a_overlap_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.overlapping) |->
      (result_o.contact_event == EvEnter || result_o.contact_event == EvStay))
    else $error("overlap reported with none or exit");

  a_apart_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.overlapping) |->
      (result_o.contact_event == EvNone || result_o.contact_event == EvExit))
    else $error("no overlap reported with enter or stay");

  a_no_item_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> (!s1_valid_q && !result_valid_o))
    else $error("item in flight during clearing pass");

  a_fwd_only_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_fwd_d) |-> $past(accept))
    else $error("forward selected without a preceding transfer");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the aabb contact event tracker
`timescale 1ns / 1ps

module testbench;
  import acet_pkg::*;

  localparam int unsigned NumColliders = NumCollidersDef;
  localparam int unsigned IdleMax      = 14;
  localparam int unsigned RandomPairs  = 1400;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  item_i;
  logic result_valid_o;
  out_t result_o;

  // touching bit per ordered pair as the testbench sees it, zero after reset
  bit   touched_pairs [NumColliders*NumColliders];
  // results still owed by the block, oldest first
  out_t pending_results [$];
  int   mismatch_count = 0;

  aabb_contact_event_tracker #(
    .NUM_COLLIDERS(NumColliders)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit: far above the slowest legal run (clearing pass plus every
  // item waiting out the longest sender gap)
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // one axis: doubled centres against full sizes, so touching edges meet
  function automatic bit spans_meet(input int cl, input int sl, input int cr, input int sr);
    return !((2*cl + sl) < (2*cr - sr) || (2*cl - sl) > (2*cr + sr));
  endfunction

  // expected event for one pair, updating the touching bits on the way
  function automatic out_t predict_contact(input in_t p);
    out_t        r;
    bit          hit;
    bit          was_touching;
    int unsigned slot;
    r.contact_event = EvNone;
    r.overlapping   = 1'b0;
    // skipped pair: an ineligible side, equal ids, or an id out of range
    if (!p.left_valid || !p.right_valid || p.left_id == p.right_id ||
        p.left_id >= NumColliders || p.right_id >= NumColliders) begin
      return r;
    end
    hit = spans_meet(int'(p.left_x), int'(p.left_w), int'(p.right_x), int'(p.right_w)) &&
          spans_meet(int'(p.left_y), int'(p.left_h), int'(p.right_y), int'(p.right_h));
    slot = p.left_id * NumColliders + p.right_id;
    was_touching = touched_pairs[slot];
    if (hit) begin
      r.contact_event = was_touching ? EvStay : EvEnter;
    end else begin
      r.contact_event = was_touching ? EvExit : EvNone;
    end
    r.overlapping       = hit;
    touched_pairs[slot] = hit;
    return r;
  endfunction

  // eligible pair with the given geometry
  function automatic in_t pair_of(input int lid, input int rid,
                                  input int lx, input int ly, input int lw, input int lh,
                                  input int rx, input int ry, input int rw, input int rh);
    in_t p;
    p.left_id     = IdW'(lid);
    p.right_id    = IdW'(rid);
    p.left_valid  = 1'b1;
    p.right_valid = 1'b1;
    p.left_x      = CoordW'(lx);
    p.left_y      = CoordW'(ly);
    p.left_w      = CoordW'(lw);
    p.left_h      = CoordW'(lh);
    p.right_x     = CoordW'(rx);
    p.right_y     = CoordW'(ry);
    p.right_w     = CoordW'(rw);
    p.right_h     = CoordW'(rh);
    return p;
  endfunction

  // idle cycles before the next item; a steady stretch sends back to back
  function automatic int unsigned draw_idle(input bit steady);
    return steady ? 0 : $urandom_range(0, IdleMax);
  endfunction

  // one transfer: idle first, then hold start until the block takes the item.
  // start is only lowered here when there is a gap, so a back-to-back item
  // keeps start high without a second assignment in the same step
  task automatic send_pair(input in_t p, input int unsigned idle);
    if (idle > 0) begin
      start  <= 1'b0;
      item_i <= in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      repeat (idle) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= p;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    pending_results.push_back(predict_contact(p));
  endtask

  // hold off the sender until every owed result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // enter, stay, exit and none on one pair; the reversed pair keeps its own bit
  task automatic test_event_sequence();
    send_pair(pair_of(1, 2, 0, 0, 64, 64, 16, 16, 64, 64), draw_idle(1'b0));
    send_pair(pair_of(1, 2, 0, 0, 64, 64, 8, -8, 32, 32), draw_idle(1'b1));
    send_pair(pair_of(1, 2, 0, 0, 64, 64, 500, 0, 64, 64), draw_idle(1'b0));
    send_pair(pair_of(1, 2, 0, 0, 64, 64, 0, -500, 64, 64), draw_idle(1'b1));
    send_pair(pair_of(2, 1, 0, 0, 64, 64, 16, 16, 64, 64), draw_idle(1'b0));
    send_pair(pair_of(1, 2, 0, 0, 64, 64, 16, 16, 64, 64), draw_idle(1'b1));
  endtask

  // skipped pairs report none and must not disturb the touching bit
  task automatic test_skipped_pairs();
    in_t p;
    send_pair(pair_of(3, 4, 0, 0, 40, 40, 10, 10, 40, 40), draw_idle(1'b0));
    p = pair_of(3, 4, 0, 0, 40, 40, 900, 900, 40, 40);
    p.left_valid = 1'b0;
    send_pair(p, draw_idle(1'b1));
    p.left_valid  = 1'b1;
    p.right_valid = 1'b0;
    send_pair(p, draw_idle(1'b0));
    p.left_valid = 1'b0;
    send_pair(p, draw_idle(1'b1));
    // bit still set, so this is a stay
    send_pair(pair_of(3, 4, 0, 0, 40, 40, 10, 10, 40, 40), draw_idle(1'b0));
    // same id on both sides, boxes overlapping
    send_pair(pair_of(5, 5, 0, 0, 40, 40, 0, 0, 40, 40), draw_idle(1'b1));
  endtask

  // touching edges, one step apart, zero sizes, extreme coordinates and ids
  task automatic test_edge_cases();
    // right box's low x edge equals left box's high x edge
    send_pair(pair_of(0, 63, 0, 0, 32, 32, 32, 0, 32, 32), draw_idle(1'b0));
    // one lsb apart: exit
    send_pair(pair_of(0, 63, 0, 0, 32, 32, 33, 0, 32, 32), draw_idle(1'b1));
    // left box's low y edge equals right box's high y edge
    send_pair(pair_of(63, 0, 0, 0, 32, 32, 0, -32, 32, 32), draw_idle(1'b0));
    // point on the border of a box
    send_pair(pair_of(62, 61, 10, 10, 0, 0, 0, 0, 20, 20), draw_idle(1'b1));
    // full-range sizes at opposite coordinate extremes meet exactly
    send_pair(pair_of(61, 62, -32768, -32768, 65535, 65535, 32767, 32767, 65535, 65535),
              draw_idle(1'b0));
    // two points on the same spot, then far apart
    send_pair(pair_of(62, 61, 7, -7, 0, 0, 7, -7, 0, 0), draw_idle(1'b1));
    send_pair(pair_of(62, 61, -32768, 32767, 0, 0, 32767, -32768, 0, 0), draw_idle(1'b0));
  endtask

  // random pair: mostly a small id pool and nearby boxes so pairs come back
  // often with hits and misses; some exact touches and some fully random items
  function automatic in_t random_pair();
    in_t         p;
    int unsigned mode;
    int          lx, ly, lw, lh, rx, ry, rw, rh;
    p = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    mode = $urandom_range(0, 9);
    p.left_valid  = ($urandom_range(0, 19) != 0);
    p.right_valid = ($urandom_range(0, 19) != 0);
    if (mode == 0) begin
      // every field but the valid bits fully random
      return p;
    end
    p.left_id  = IdW'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 7)
                                                 : $urandom_range(0, 63));
    p.right_id = IdW'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 7)
                                                 : $urandom_range(0, 63));
    lx = int'($urandom_range(0, 4000)) - 2000;
    ly = int'($urandom_range(0, 4000)) - 2000;
    lw = $urandom_range(0, 600);
    lh = $urandom_range(0, 600);
    rw = $urandom_range(0, 600);
    rh = $urandom_range(0, 600);
    rx = lx + int'($urandom_range(0, 1200)) - 600;
    ry = ly + int'($urandom_range(0, 1200)) - 600;
    if (mode == 1) begin
      // edges meet exactly on x, on either side; even sizes keep it exact
      lw = lw & ~1;
      rw = rw & ~1;
      rx = $urandom_range(0, 1) ? lx + (lw + rw) / 2 : lx - (lw + rw) / 2;
      ry = ly;
    end else if (mode == 2) begin
      lh = lh & ~1;
      rh = rh & ~1;
      ry = $urandom_range(0, 1) ? ly + (lh + rh) / 2 : ly - (lh + rh) / 2;
      rx = lx;
    end
    p.left_x  = CoordW'(lx);
    p.left_y  = CoordW'(ly);
    p.left_w  = CoordW'(lw);
    p.left_h  = CoordW'(lh);
    p.right_x = CoordW'(rx);
    p.right_y = CoordW'(ry);
    p.right_w = CoordW'(rw);
    p.right_h = CoordW'(rh);
    return p;
  endfunction

  task automatic test_random_pairs();
    bit steady;
    steady = 1'b0;
    for (int n = 0; n < RandomPairs; n++) begin
      // switch between back-to-back stretches and random gaps
      if (n % 64 == 0) steady = ($urandom_range(0, 2) == 0);
      // once midway the sender waits for every result to come back
      if (n == RandomPairs / 2) drain_results();
      send_pair(random_pair(), draw_idle(steady));
    end
  endtask

  // every strobe is checked against the oldest expectation
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (result_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: event %0d overlapping %0b",
                 $time, result_o.contact_event, result_o.overlapping);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_o.contact_event !== want.contact_event) begin
          $display("%0t: contact_event expected %0d actual %0d",
                   $time, want.contact_event, result_o.contact_event);
          mismatch_count++;
        end
        if (result_o.overlapping !== want.overlapping) begin
          $display("%0t: overlapping expected %0b actual %0b",
                   $time, want.overlapping, result_o.overlapping);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    // all inputs known and reset low from time zero
    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // the clearing pass keeps busy high; the first transfer simply waits on it
    test_event_sequence();
    test_skipped_pairs();
    test_edge_cases();
    test_random_pairs();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // keep the clock running to catch any stray strobe
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/acet_pkg.sv
rtl/acet_axis_overlap.sv
rtl/aabb_contact_event_tracker.sv
verif/testbench.sv
